>>> hdl/outline_path_flattener_core_macros.svh
// assertion macros for the outline path flattener core
// needs clk and arst_n in the scope where a macro is used
`ifndef OUTLINE_PATH_FLATTENER_CORE_MACROS_SVH
`define OUTLINE_PATH_FLATTENER_CORE_MACROS_SVH

// same-cycle implication
`define OPF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OPF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/opf_pkg.sv
// shared types and constants for the outline path flattener core
// no dependencies
`default_nettype none

package opf_pkg;

	localparam int MAX_DEPTH_DEF  = 6;
	localparam int COUNT_BITS_DEF = 16;
	localparam int COORD_W        = 24;
	localparam int CNT_OUT_W      = 16;
	localparam int DEPTH_CFG_W    = 3;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 3;

	localparam logic [DEPTH_CFG_W-1:0] DEPTH_RESET = 3'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DUP   = 1'b1;

	typedef enum logic [1:0] {
		OP_MOVE  = 2'd0,
		OP_LINE  = 2'd1,
		OP_CONIC = 2'd2,
		OP_CUBIC = 2'd3
	} op_t;

	// control from the sequencer to the coordinate step units
	typedef struct packed {
		logic load;   // take a new command, set up the difference registers
		logic conic;  // load sets up a conic, else a single hard point
		logic step;   // produce one point into the output register
		logic zero;   // the produced point is forced to zero
	} ctl_t;

endpackage

`default_nettype wire

>>> hdl/opf_step_unit.sv
// forward-difference step unit for one coordinate, holds the current point
// depends on opf_pkg
`default_nettype none

module opf_step_unit #(
	parameter int MAX_DEPTH = opf_pkg::MAX_DEPTH_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire opf_pkg::ctl_t                           ctl,
	input  wire logic [$clog2(MAX_DEPTH+1)-1:0]          depth,
	input  wire logic signed [opf_pkg::COORD_W-1:0]      ctrl,
	input  wire logic signed [opf_pkg::COORD_W-1:0]      target,
	output logic signed [opf_pkg::COORD_W+2*MAX_DEPTH-1:0] point
);

	localparam int PW = opf_pkg::COORD_W + 2 * MAX_DEPTH;
	localparam int SW = $clog2(2 * MAX_DEPTH + 1);

	logic signed [opf_pkg::COORD_W-1:0] cur_q;
	logic signed [PW-1:0] f_q, d1_q, d2_q, pt_q;

	logic signed [PW-1:0] a_w, c_w, t_w, s_w, ca_w, d1_init, d2_init, f_init, sum_w;
	logic [SW-1:0] dx, sh_s, sh_ca, sh_d2;

	// all arithmetic wraps at the point width, which is exact modulo the output range
	always_comb begin
		a_w   = PW'(cur_q);
		c_w   = PW'(ctrl);
		t_w   = PW'(target);
		dx    = SW'(depth);
		sh_s  = SW'(2 * MAX_DEPTH) - (dx << 1);
		sh_ca = SW'(2 * MAX_DEPTH + 1) - dx;
		sh_d2 = sh_s + SW'(1);
		s_w   = a_w - (c_w <<< 1) + t_w;
		ca_w  = c_w - a_w;
		if (ctl.conic) begin
			f_init  = a_w <<< (2 * MAX_DEPTH);
			d1_init = (s_w <<< sh_s) + (ca_w <<< sh_ca);
			d2_init = s_w <<< sh_d2;
		end else begin
			f_init  = t_w <<< (2 * MAX_DEPTH);
			d1_init = '0;
			d2_init = '0;
		end
		sum_w = f_q + d1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (ctl.load) begin
			cur_q <= target;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			f_q  <= f_init;
			d1_q <= d1_init;
			d2_q <= d2_init;
		end else if (ctl.step) begin
			f_q  <= sum_w;
			d1_q <= d1_q + d2_q;
		end
		if (ctl.step) begin
			pt_q <= ctl.zero ? '0 : sum_w;
		end
	end

	assign point = pt_q;

endmodule

`default_nettype wire

>>> hdl/opf_seq.sv
// command sequencer: config registers, counters, output word control
// depends on opf_pkg and outline_path_flattener_core_macros.svh
`default_nettype none

`include "outline_path_flattener_core_macros.svh"

module opf_seq #(
	parameter int MAX_DEPTH  = opf_pkg::MAX_DEPTH_DEF,
	parameter int COUNT_BITS = opf_pkg::COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [opf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [opf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        operation,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [opf_pkg::CNT_OUT_W-1:0]          point_index,
	output logic [opf_pkg::CNT_OUT_W-1:0]          contour_number,
	output logic [opf_pkg::CNT_OUT_W-1:0]          points_in_contour,
	output logic                                   status,
	output logic                                   last,
	output opf_pkg::ctl_t                          ctl,
	output logic [$clog2(MAX_DEPTH+1)-1:0]         depth
);

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int RW = MAX_DEPTH + 1;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic [opf_pkg::DEPTH_CFG_W-1:0] depth_cfg_q;
	logic dup_q;
	logic cubic_q;
	logic [RW-1:0] rem_q;
	logic [COUNT_BITS-1:0] total_q, cpc_q, contour_q;
	logic out_valid_q, status_q, last_q;
	logic [opf_pkg::CNT_OUT_W-1:0] idx_q, cnum_q, cip_q;

	opf_pkg::op_t op_w;
	logic accept, step;
	logic [RW-1:0] n_w;
	logic [COUNT_BITS-1:0] total_inc, cpc_inc, contour_inc;

	always_comb begin
		op_w = opf_pkg::op_t'(operation);
		if (depth_cfg_q > MAX_DEPTH) begin
			depth = DW'(MAX_DEPTH);
		end else if (depth_cfg_q == '0) begin
			depth = DW'(1);
		end else begin
			depth = DW'(depth_cfg_q);
		end
		accept = in_valid && (state_q == ST_IDLE);
		step   = (state_q == ST_RUN) && (!out_valid_q || !out_stall);
		case (op_w)
			opf_pkg::OP_CONIC: n_w = RW'(1) << depth;
			opf_pkg::OP_CUBIC: n_w = RW'(1);
			default:           n_w = dup_q ? RW'(2) : RW'(1);
		endcase
		// saturating counters
		total_inc   = (total_q == '1) ? total_q : total_q + 1'b1;
		cpc_inc     = (cpc_q == '1) ? cpc_q : cpc_q + 1'b1;
		contour_inc = (contour_q == '1) ? contour_q : contour_q + 1'b1;
		ctl.load  = accept && (op_w != opf_pkg::OP_CUBIC);
		ctl.conic = (op_w == opf_pkg::OP_CONIC);
		ctl.step  = step;
		ctl.zero  = cubic_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_cfg_q <= opf_pkg::DEPTH_RESET;
			dup_q       <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				opf_pkg::REG_DEPTH: depth_cfg_q <= cfg_data;
				opf_pkg::REG_DUP:   dup_q <= cfg_data[0];
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cubic_q     <= 1'b0;
			rem_q       <= '0;
			total_q     <= '0;
			cpc_q       <= '0;
			contour_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						cubic_q <= (op_w == opf_pkg::OP_CUBIC);
						rem_q   <= n_w;
						if (op_w == opf_pkg::OP_MOVE) begin
							contour_q <= contour_inc;
							cpc_q     <= '0;
						end
					end
				end
				ST_RUN: begin
					if (step) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == RW'(1)) begin
							state_q <= ST_IDLE;
						end
						if (!cubic_q) begin
							total_q <= total_inc;
							cpc_q   <= cpc_inc;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (step) begin
			idx_q    <= opf_pkg::CNT_OUT_W'(total_q);
			cnum_q   <= opf_pkg::CNT_OUT_W'(contour_q);
			cip_q    <= cubic_q ? opf_pkg::CNT_OUT_W'(cpc_q) : opf_pkg::CNT_OUT_W'(cpc_inc);
			status_q <= cubic_q;
			last_q   <= (rem_q == RW'(1));
		end
	end

	assign in_stall          = (state_q != ST_IDLE);
	assign out_valid         = out_valid_q;
	assign point_index       = idx_q;
	assign contour_number    = cnum_q;
	assign points_in_contour = cip_q;
	assign status            = status_q;
	assign last              = last_q;

	`OPF_ASSERT_NXT(ast_accept_runs, accept, state_q == ST_RUN && rem_q != '0, "accepted word did not start a run")
	`OPF_ASSERT_NXT(ast_cubic_single, accept && op_w == opf_pkg::OP_CUBIC, rem_q == RW'(1) && cubic_q, "cubic must give one word")
	`OPF_ASSERT_IMP(ast_status_last, out_valid_q && status_q, last_q, "status word must be last")
	`OPF_ASSERT_NXT(ast_total_inc, step && !cubic_q && total_q != '1, total_q == $past(total_q) + 1'b1, "point count did not advance")

endmodule

`default_nettype wire

>>> hdl/outline_path_flattener_core.sv
// outline path flattener core: one command in, one or more points out.
// the first result word is registered on the first step after acceptance.
// a command gives n words from the step units, one per cycle unless output stall
// holds them; no new command is taken before the last. n is 2^depth for a conic
// (depth clamped to 1..MAX_DEPTH), 1 or 2 for move/line, 1 for cubic.
// reset: asynchronous active low; clears counters, current point, depth to 2.
`default_nettype none

module outline_path_flattener_core #(
	parameter int MAX_DEPTH  = opf_pkg::MAX_DEPTH_DEF,
	parameter int COUNT_BITS = opf_pkg::COUNT_BITS_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       cfg_write,
	input  wire logic [opf_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  wire logic [opf_pkg::CFG_DATA_W-1:0]             cfg_data,
	input  wire logic                                       in_valid,
	output logic                                            in_stall,
	input  wire logic [1:0]                                 operation,
	input  wire logic signed [opf_pkg::COORD_W-1:0]         ctrl_x,
	input  wire logic signed [opf_pkg::COORD_W-1:0]         ctrl_y,
	input  wire logic signed [opf_pkg::COORD_W-1:0]         to_x,
	input  wire logic signed [opf_pkg::COORD_W-1:0]         to_y,
	output logic                                            out_valid,
	input  wire logic                                       out_stall,
	output logic signed [opf_pkg::COORD_W+2*MAX_DEPTH-1:0]  point_x,
	output logic signed [opf_pkg::COORD_W+2*MAX_DEPTH-1:0]  point_y,
	output logic [opf_pkg::CNT_OUT_W-1:0]                   point_index,
	output logic [opf_pkg::CNT_OUT_W-1:0]                   contour_number,
	output logic [opf_pkg::CNT_OUT_W-1:0]                   points_in_contour,
	output logic                                            status,
	output logic                                            last
);

	opf_pkg::ctl_t ctl;
	logic [$clog2(MAX_DEPTH+1)-1:0] depth;

	opf_seq #(
		.MAX_DEPTH  (MAX_DEPTH),
		.COUNT_BITS (COUNT_BITS)
	) u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.operation         (operation),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.point_index       (point_index),
		.contour_number    (contour_number),
		.points_in_contour (points_in_contour),
		.status            (status),
		.last              (last),
		.ctl               (ctl),
		.depth             (depth)
	);

	opf_step_unit #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_step_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.depth  (depth),
		.ctrl   (ctrl_x),
		.target (to_x),
		.point  (point_x)
	);

	opf_step_unit #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_step_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.depth  (depth),
		.ctrl   (ctrl_y),
		.target (to_y),
		.point  (point_y)
	);

endmodule

`default_nettype wire
